/* src/bairs_pkg.sv */
// Shared constants, request codes and controller/datapath types for the byte array block.
`default_nettype none

package bairs_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int BW    = 8;
  localparam int REQW  = 4;
  localparam int IDXW  = 8;
  localparam int ENDW  = 9;
  localparam int LENW  = 9;

  localparam logic [LENW-1:0] LEN_RESET = LENW'(256);

  localparam logic [REQW-1:0] REQ_PUSH       = 4'd0;
  localparam logic [REQW-1:0] REQ_POP        = 4'd1;
  localparam logic [REQW-1:0] REQ_SHIFT      = 4'd2;
  localparam logic [REQW-1:0] REQ_UNSHIFT    = 4'd3;
  localparam logic [REQW-1:0] REQ_READ       = 4'd4;
  localparam logic [REQW-1:0] REQ_WRITE      = 4'd5;
  localparam logic [REQW-1:0] REQ_REMOVE     = 4'd6;
  localparam logic [REQW-1:0] REQ_FIND_FIRST = 4'd7;
  localparam logic [REQW-1:0] REQ_FIND_LAST  = 4'd8;
  localparam logic [REQW-1:0] REQ_CLEAR      = 4'd9;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_DECODE,
    OP_RDWAIT,
    OP_MOVE,
    OP_SCAN,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
    logic   in_ready;
  } cmd_t;

  typedef struct packed {
    logic [REQW-1:0] req;
    logic            ok;
    logic            len_zero;
    logic            last_walk;
    logic            last_clear;
    logic            hit;
    logic            out_free;
  } stat_t;

endpackage

`default_nettype wire

/* src/bairs_if.sv */
// Request, result and configuration channel interfaces.
`default_nettype none

interface bairs_req_if import bairs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [REQW-1:0] req_type;
  logic [IDXW-1:0] index;
  logic [ENDW-1:0] end_index;
  logic [BW-1:0]   value;

  modport source (output valid, req_type, index, end_index, value, input ready);
  modport sink   (input valid, req_type, index, end_index, value, output ready);
endinterface

interface bairs_rsp_if import bairs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [BW-1:0]   read_byte;
  logic [IDXW-1:0] position;
  logic            found;
  logic            accepted;
  logic [CW-1:0]   fill_count;

  modport source (output valid, read_byte, position, found, accepted, fill_count,
                  input ready);
  modport sink   (input valid, read_byte, position, found, accepted, fill_count,
                  output ready);
endinterface

interface bairs_cfg_if import bairs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LENW-1:0] array_length;

  modport source (output valid, array_length, input ready);
  modport sink   (input valid, array_length, output ready);
endinterface

`default_nettype wire

/* src/byte_array_insert_remove_search.sv */
// Top level of the byte array store with insert, remove and search requests.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, index, end_index, value
//   rsp      out  valid/ready   read_byte, position, found, accepted, fill_count
//   cfg      in   valid/ready   array_length (ready always high)
//
// One request at a time. Shift, unshift and range removal: one RAM slot per cycle from
// the start slot up to the length.
// Shift, unshift, removal and clear sweeps are paced by the single write port of the byte RAM.
// After reset a clearing pass zeroes the RAM; req.ready stays low.
// A new request is taken while the previous result still waits in the output register.
`default_nettype none

module byte_array_insert_remove_search import bairs_pkg::*; (
  input logic         clk,
  input logic         rst,
  bairs_req_if.sink   req,
  bairs_rsp_if.source rsp,
  bairs_cfg_if.sink   cfg
);

  cmd_t  cmd;
  stat_t stat;

  bairs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  bairs_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg)
  );

endmodule

`default_nettype wire

/* src/bairs_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module bairs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/bairs_ctrl.sv */
// Sequencer for the byte array: accepts a request, runs any sweep it needs, hands off the result.
`default_nettype none

module bairs_ctrl import bairs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLR_RST  = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_DECODE   = 10'b0000000100,
    S_RDWAIT   = 10'b0000001000,
    S_MOVE     = 10'b0000010000,
    S_DRAIN    = 10'b0000100000,
    S_SCAN     = 10'b0001000000,
    S_SCAN_END = 10'b0010000000,
    S_CLR      = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_RST;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    done         = 1'b0;
    cmd.op       = OP_NONE;
    cmd.load     = 1'b0;
    cmd.in_ready = 1'b0;
    case (state)
      S_CLR_RST: begin
        cmd.op = OP_CLEAR;
        if (stat.last_clear) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_TAKE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op = OP_DECODE;
        if (!stat.ok) begin
          done = 1'b1;
        end else begin
          case (stat.req)
            REQ_POP, REQ_READ, REQ_SHIFT: state_next = S_RDWAIT;
            REQ_UNSHIFT, REQ_REMOVE:      state_next = S_MOVE;
            REQ_FIND_FIRST, REQ_FIND_LAST: begin
              if (stat.len_zero) begin
                done = 1'b1;
              end else begin
                state_next = S_SCAN;
              end
            end
            REQ_CLEAR:                    state_next = S_CLR;
            default:                      done = 1'b1;
          endcase
        end
      end
      S_RDWAIT: begin
        cmd.op = OP_RDWAIT;
        if (stat.req == REQ_SHIFT) begin
          state_next = S_MOVE;
        end else begin
          done = 1'b1;
        end
      end
      S_MOVE: begin
        cmd.op = OP_MOVE;
        if (stat.last_walk) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last pending write lands this cycle
        done = 1'b1;
      end
      S_SCAN: begin
        if (stat.hit) begin
          done = 1'b1;
        end else begin
          cmd.op = OP_SCAN;
          if (stat.last_walk) begin
            state_next = S_SCAN_END;
          end
        end
      end
      S_SCAN_END: begin
        done = 1'b1;
      end
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (stat.last_clear) begin
          done = 1'b1;
        end
      end
      S_FIN: begin
        done = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (done) begin
      cmd.load   = stat.out_free;
      state_next = stat.out_free ? S_IDLE : S_FIN;
    end
  end

endmodule

`default_nettype wire

/* src/bairs_dp.sv */
// Datapath: byte store RAM, count and length, sweep pointer, write stage and result registers.
`default_nettype none

module bairs_dp import bairs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  bairs_req_if.sink         req,
  bairs_rsp_if.source       rsp,
  bairs_cfg_if.sink         cfg
);

  typedef enum logic [1:0] {
    SEL_RAM,
    SEL_ZERO,
    SEL_VAL
  } wsel_t;

  // latched request
  logic [REQW-1:0] req_q, req_q_next;
  logic [IDXW-1:0] idx_q, idx_q_next;
  logic [ENDW-1:0] endi_q, endi_q_next;
  logic [BW-1:0]   val_q, val_q_next;

  logic [CW-1:0]   count, count_next;
  logic [LENW-1:0] length, length_next;
  logic [CW-1:0]   ptr, ptr_next;
  logic [CW-1:0]   dif, dif_next;

  // write stage behind the registered RAM read
  logic            wv, wv_next;
  logic [AW-1:0]   wa, wa_next;
  wsel_t           wsel, wsel_next;

  // compare stage for searches
  logic            cv, cv_next;
  logic [AW-1:0]   ca, ca_next;

  logic [BW-1:0]   res_rd, res_rd_next;
  logic [IDXW-1:0] res_pos, res_pos_next;
  logic            res_fnd, res_fnd_next;
  logic            res_acc, res_acc_next;

  logic            out_valid, out_valid_next;
  logic [BW-1:0]   out_rd, out_rd_next;
  logic [IDXW-1:0] out_pos, out_pos_next;
  logic            out_fnd, out_fnd_next;
  logic            out_acc, out_acc_next;
  logic [CW-1:0]   out_cnt, out_cnt_next;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [BW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [BW-1:0]   ram_rdata;

  logic [CW-1:0]   len_eff;
  logic [CW-1:0]   lm1;
  logic [CW-1:0]   count_m1;
  logic [CW-1:0]   cfg_len;
  logic [CW-1:0]   rm_len;
  logic [CW:0]     src;
  logic            src_in;
  logic            walk_up;
  logic            ok;
  logic            hit;

  bairs_ram #(.WIDTH(BW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign len_eff  = (length > LENW'(DEPTH)) ? CW'(DEPTH) : CW'(length);
  assign lm1      = len_eff - CW'(1);
  assign count_m1 = count - CW'(1);
  assign cfg_len  = (cfg.array_length > LENW'(DEPTH)) ? CW'(DEPTH) : CW'(cfg.array_length);
  assign rm_len   = CW'(endi_q - ENDW'(idx_q));
  assign src      = {1'b0, ptr} + {1'b0, dif};
  assign src_in   = src < {1'b0, len_eff};
  assign walk_up  = (req_q == REQ_UNSHIFT) || (req_q == REQ_FIND_LAST);
  assign hit      = cv && (ram_rdata == val_q);

  always_comb begin
    case (req_q)
      REQ_PUSH:                 ok = count < len_eff;
      REQ_POP, REQ_SHIFT:       ok = count != '0;
      REQ_UNSHIFT:              ok = len_eff >= CW'(2);
      REQ_READ:                 ok = CW'(idx_q) < count;
      REQ_WRITE:                ok = CW'(idx_q) < len_eff;
      REQ_REMOVE:               ok = (ENDW'(idx_q) < endi_q) && (endi_q <= ENDW'(count));
      REQ_FIND_FIRST, REQ_FIND_LAST, REQ_CLEAR: ok = 1'b1;
      default:                  ok = 1'b0;
    endcase
  end

  assign stat.req        = req_q;
  assign stat.ok         = ok;
  assign stat.len_zero   = len_eff == '0;
  assign stat.last_walk  = walk_up ? (ptr == '0) : (ptr == lm1);
  assign stat.last_clear = ptr == CW'(DEPTH - 1);
  assign stat.hit        = hit;
  assign stat.out_free   = !out_valid || rsp.ready;

  assign req.ready = cmd.in_ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid      = out_valid;
  assign rsp.read_byte  = out_rd;
  assign rsp.position   = out_pos;
  assign rsp.found      = out_fnd;
  assign rsp.accepted   = out_acc;
  assign rsp.fill_count = out_cnt;

  always_comb begin
    req_q_next   = req_q;
    idx_q_next   = idx_q;
    endi_q_next  = endi_q;
    val_q_next   = val_q;
    count_next   = count;
    length_next  = length;
    ptr_next     = ptr;
    dif_next     = dif;
    wv_next      = 1'b0;
    wa_next      = wa;
    wsel_next    = wsel;
    cv_next      = 1'b0;
    ca_next      = ca;
    res_rd_next  = res_rd;
    res_pos_next = res_pos;
    res_fnd_next = res_fnd;
    res_acc_next = res_acc;

    // pending write from the sweep stage
    ram_we    = wv;
    ram_waddr = wa;
    case (wsel)
      SEL_RAM: ram_wdata = ram_rdata;
      SEL_VAL: ram_wdata = val_q;
      default: ram_wdata = '0;
    endcase
    ram_raddr = ptr[AW-1:0];

    if (cfg.valid) begin
      length_next = cfg.array_length;
      if (count > cfg_len) begin
        count_next = cfg_len;
      end
    end

    case (cmd.op)
      OP_TAKE: begin
        req_q_next  = req.req_type;
        idx_q_next  = req.index;
        endi_q_next = req.end_index;
        val_q_next  = req.value;
      end
      OP_DECODE: begin
        res_rd_next  = '0;
        res_pos_next = '0;
        res_fnd_next = 1'b0;
        res_acc_next = ok;
        case (req_q)
          REQ_PUSH: begin
            if (ok) begin
              ram_we     = 1'b1;
              ram_waddr  = count[AW-1:0];
              ram_wdata  = val_q;
              count_next = count + CW'(1);
            end
          end
          REQ_POP: begin
            ram_raddr = count_m1[AW-1:0];
            if (ok) begin
              count_next = count_m1;
            end
          end
          REQ_SHIFT: begin
            ram_raddr = '0;
            ptr_next  = '0;
            dif_next  = CW'(1);
            if (ok) begin
              count_next = count_m1;
            end
          end
          REQ_UNSHIFT: begin
            ptr_next = lm1;
            if (ok && (count < len_eff)) begin
              count_next = count + CW'(1);
            end
          end
          REQ_READ: begin
            ram_raddr = AW'(idx_q);
          end
          REQ_WRITE: begin
            if (ok) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(idx_q);
              ram_wdata = val_q;
            end
          end
          REQ_REMOVE: begin
            ptr_next = CW'(idx_q);
            dif_next = rm_len;
            if (ok) begin
              count_next = count - rm_len;
            end
          end
          REQ_FIND_FIRST: ptr_next = '0;
          REQ_FIND_LAST:  ptr_next = lm1;
          REQ_CLEAR: begin
            ptr_next   = '0;
            count_next = '0;
          end
          default: ;
        endcase
      end
      OP_RDWAIT: begin
        res_rd_next = ram_rdata;
      end
      OP_MOVE: begin
        wv_next = 1'b1;
        wa_next = ptr[AW-1:0];
        if (walk_up) begin
          // unshift: copy slot below upward, new value lands at slot 0
          ram_raddr = ptr[AW-1:0] - AW'(1);
          wsel_next = (ptr == '0) ? SEL_VAL : SEL_RAM;
          ptr_next  = ptr - CW'(1);
        end else begin
          // close the gap; slots fed from beyond the length get zero
          ram_raddr = src[AW-1:0];
          wsel_next = src_in ? SEL_RAM : SEL_ZERO;
          ptr_next  = ptr + CW'(1);
        end
      end
      OP_SCAN: begin
        ram_raddr = ptr[AW-1:0];
        cv_next   = 1'b1;
        ca_next   = ptr[AW-1:0];
        ptr_next  = walk_up ? (ptr - CW'(1)) : (ptr + CW'(1));
      end
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[AW-1:0];
        ram_wdata = '0;
        ptr_next  = ptr + CW'(1);
      end
      default: ;
    endcase

    if (hit) begin
      res_pos_next = IDXW'(ca);
      res_fnd_next = 1'b1;
    end
  end

  always_comb begin
    out_rd_next    = out_rd;
    out_pos_next   = out_pos;
    out_fnd_next   = out_fnd;
    out_acc_next   = out_acc;
    out_cnt_next   = out_cnt;
    out_valid_next = out_valid;
    if (cmd.load) begin
      out_rd_next    = res_rd_next;
      out_pos_next   = res_pos_next;
      out_fnd_next   = res_fnd_next;
      out_acc_next   = res_acc_next;
      out_cnt_next   = count_next;
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      length    <= LEN_RESET;
      ptr       <= '0;
      wv        <= 1'b0;
      cv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      length    <= length_next;
      ptr       <= ptr_next;
      wv        <= wv_next;
      cv        <= cv_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q   <= req_q_next;
    idx_q   <= idx_q_next;
    endi_q  <= endi_q_next;
    val_q   <= val_q_next;
    dif     <= dif_next;
    wa      <= wa_next;
    wsel    <= wsel_next;
    ca      <= ca_next;
    res_rd  <= res_rd_next;
    res_pos <= res_pos_next;
    res_fnd <= res_fnd_next;
    res_acc <= res_acc_next;
    out_rd  <= out_rd_next;
    out_pos <= out_pos_next;
    out_fnd <= out_fnd_next;
    out_acc <= out_acc_next;
    out_cnt <= out_cnt_next;
  end

endmodule

`default_nettype wire
